// ===== rtl/tsag_pkg.sv =====
// ----------------------------------------------------------------------------
// tsag_pkg
// Shared types, limits and register codes of the tile source address generator.
// ----------------------------------------------------------------------------
package tsag_pkg;

  localparam logic [12:0] MAX_IMAGE = 13'd4096;
  localparam logic [10:0] MAX_TILE  = 11'd1024;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TILE_SIZE    = 3'd2,
    REG_OVERLAP      = 3'd3,
    REG_REFLECT_MODE = 3'd4
  } cfg_reg_t;

  // Configuration after saturation, with the derived mirror periods.
  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] wm1;
    logic [12:0] hm1;
    logic [12:0] per_x;
    logic [12:0] per_y;
    logic        w_small;
    logic        h_small;
    logic [10:0] ts;
    logic [8:0]  ov;
    logic        refl;
  } cfg_t;

  typedef struct packed {
    logic signed [13:0] c;
    logic [9:0]         off;
  } axis_front_t;

  typedef struct packed {
    axis_front_t x;
    axis_front_t y;
  } front_item_t;

  typedef struct packed {
    logic [12:0] r;
    logic        neg;
    logic [11:0] cl;
    logic        lt;
  } axis_mod_t;

  typedef struct packed {
    axis_mod_t x;
    axis_mod_t y;
    logic      hit;
  } mod_item_t;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic        zf;
    logic        hit;
  } src_item_t;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic [23:0] addr;
    logic        zf;
    logic        hit;
  } res_item_t;

endpackage

// ===== rtl/tsag_front.sv =====
// ----------------------------------------------------------------------------
// tsag_front
// Accepts tile items, forms the padded coordinates and holds them in a
// four-entry queue for the back end.
// ----------------------------------------------------------------------------
module tsag_front import tsag_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        push,
  output logic        full,
  input  logic [11:0] tile_x,
  input  logic [11:0] tile_y,
  input  logic [9:0]  off_x,
  input  logic [9:0]  off_y,
  input  logic        take,
  output logic        head_valid,
  output front_item_t head
);

  localparam int unsigned DEPTH = 4;

  front_item_t entries [DEPTH];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  count;
  logic        wr;
  logic        rd;
  front_item_t item;

  function automatic axis_front_t axis_front(input logic [11:0] t, input logic [9:0] off,
                                             input logic [8:0] ov, input logic refl);
    logic signed [13:0] o;
    logic signed [13:0] org;
    axis_front_t        a;
    o = $signed({2'b00, t}) - $signed({5'd0, ov});
    org = (!refl && o < 0) ? 14'sd0 : o;
    a.c = org + $signed({4'd0, off});
    a.off = off;
    return a;
  endfunction

  assign full       = (count == 3'(DEPTH));
  assign head_valid = (count != 3'd0);
  assign head       = entries[rptr];
  assign wr         = push && !full;
  assign rd         = take && head_valid;

  always_comb begin
    item.x = axis_front(tile_x, off_x, cfg.ov, cfg.refl);
    item.y = axis_front(tile_y, off_y, cfg.ov, cfg.refl);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 2'd1;
      end
      if (rd) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(wr) - 3'(rd);
    end
  end

endmodule

// ===== rtl/tsag_mirror.sv =====
// ----------------------------------------------------------------------------
// tsag_mirror
// Fixed-latency pipeline that reduces both coordinates modulo the mirror
// period two quotient bits per stage; reflect mode folds them into the image.
// ----------------------------------------------------------------------------
module tsag_mirror import tsag_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  input  front_item_t in_item,
  output logic        out_valid,
  output src_item_t   out_item
);

  localparam int unsigned NSTAGE = 6;

  mod_item_t st  [NSTAGE+1];
  logic      vld [NSTAGE+1];
  mod_item_t entry;

  function automatic axis_mod_t axis_entry(input axis_front_t a, input logic [12:0] dim);
    logic signed [13:0] mag;
    axis_mod_t          m;
    mag   = a.c[13] ? -a.c : a.c;
    m.r   = mag[12:0];
    m.neg = a.c[13];
    m.cl  = a.c[11:0];
    m.lt  = a.c < $signed({1'b0, dim});
    return m;
  endfunction

  function automatic logic [12:0] mod_step(input logic [12:0] r, input logic [12:0] p,
                                           input logic [3:0] k);
    logic [12:0] q;
    q = r >> k;
    return (q >= p) ? (r - (p << k)) : r;
  endfunction

  function automatic logic [11:0] fold(input axis_mod_t a, input logic [12:0] per,
                                       input logic [12:0] dm1, input logic [12:0] dim,
                                       input logic degen);
    logic [12:0] alt;
    logic        use_alt;
    logic [12:0] m;
    alt     = per - a.r;
    use_alt = (a.neg && a.r != 13'd0) ? (a.r >= dm1) : (a.r >= dim);
    m       = use_alt ? alt : a.r;
    return degen ? 12'd0 : m[11:0];
  endfunction

  always_comb begin
    entry.x   = axis_entry(in_item.x, cfg.w);
    entry.y   = axis_entry(in_item.y, cfg.h);
    entry.hit = ({1'b0, in_item.x.off} < cfg.ts) && ({1'b0, in_item.y.off} < cfg.ts)
                && (cfg.refl || (entry.x.lt && entry.y.lt));
  end

  always_ff @(posedge clk) begin
    st[0] <= entry;
  end

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    localparam logic [3:0] K_HI = 4'(2 * (NSTAGE - s) - 1);
    localparam logic [3:0] K_LO = 4'(2 * (NSTAGE - s) - 2);
    mod_item_t nxt;
    always_comb begin
      nxt     = st[s];
      nxt.x.r = mod_step(mod_step(st[s].x.r, cfg.per_x, K_HI), cfg.per_x, K_LO);
      nxt.y.r = mod_step(mod_step(st[s].y.r, cfg.per_y, K_HI), cfg.per_y, K_LO);
    end
    always_ff @(posedge clk) begin
      st[s+1] <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.refl) begin
      out_item.sx <= fold(st[NSTAGE].x, cfg.per_x, cfg.wm1, cfg.w, cfg.w_small);
      out_item.sy <= fold(st[NSTAGE].y, cfg.per_y, cfg.hm1, cfg.h, cfg.h_small);
      out_item.zf <= 1'b0;
    end else if (st[NSTAGE].x.lt && st[NSTAGE].y.lt) begin
      out_item.sx <= st[NSTAGE].x.cl;
      out_item.sy <= st[NSTAGE].y.cl;
      out_item.zf <= 1'b0;
    end else begin
      out_item.sx <= 12'd0;
      out_item.sy <= 12'd0;
      out_item.zf <= 1'b1;
    end
    out_item.hit <= st[NSTAGE].hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NSTAGE; i++) begin
        vld[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < NSTAGE; i++) begin
        vld[i+1] <= vld[i];
      end
      out_valid <= vld[NSTAGE];
    end
  end

endmodule

// ===== rtl/tsag_back.sv =====
// ----------------------------------------------------------------------------
// tsag_back
// Forms the plane address, buffers results in a sixteen-entry queue and
// grants issue credits so that the pipeline in front of it never stalls.
// ----------------------------------------------------------------------------
module tsag_back import tsag_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        issue,
  output logic        credit,
  input  logic        in_valid,
  input  src_item_t   in_item,
  input  logic        pop,
  output logic        empty,
  output res_item_t   head
);

  localparam int unsigned DEPTH = 16;

  src_item_t   mul_item;
  logic        mul_valid;
  logic [24:0] prod;
  logic [24:0] sum;
  res_item_t   wr_item;
  res_item_t   entries [DEPTH];
  logic [3:0]  wptr;
  logic [3:0]  rptr;
  logic [4:0]  count;
  logic [4:0]  occ;
  logic        rd;

  assign rd     = pop && !empty;
  assign empty  = (count == 5'd0);
  assign head   = entries[rptr];
  assign credit = (occ < 5'(DEPTH));
  assign sum    = prod + {13'd0, mul_item.sx};

  always_comb begin
    wr_item.sx   = mul_item.sx;
    wr_item.sy   = mul_item.sy;
    wr_item.addr = sum[23:0];
    wr_item.zf   = mul_item.zf;
    wr_item.hit  = mul_item.hit;
  end

  always_ff @(posedge clk) begin
    mul_item <= in_item;
    prod     <= {13'd0, in_item.sy} * {12'd0, cfg.w};
    if (mul_valid) begin
      entries[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      occ       <= '0;
    end else begin
      mul_valid <= in_valid;
      if (mul_valid) begin
        wptr <= wptr + 4'd1;
      end
      if (rd) begin
        rptr <= rptr + 4'd1;
      end
      count <= count + 5'(mul_valid) - 5'(rd);
      occ   <= occ + 5'(issue) - 5'(rd);
    end
  end

endmodule

// ===== rtl/tile_source_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// tile_source_address_generator_core
// Maps a pixel of a padded tile to its source coordinate and plane address,
// with mirror or zero-fill padding at the image edges.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  input     push / full        tile_x, tile_y, off_x, off_y
//  result    empty / pop        src_x, src_y, src_addr, zero_fill, in_tile
//  config    cfg_valid / ready  cfg_index, cfg_data
//
// One item is taken per cycle while the front queue is not full; each result
// passes the six-stage modulo pipeline plus fold, multiply and entry stages.
// Reset clears both queues and loads the register reset values.
// The input side stalls only when the four-entry front queue fills, which
// happens when the sixteen-entry result queue has no credit left.
module tile_source_address_generator_core import tsag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [11:0]           tile_x,
  input  logic [11:0]           tile_y,
  input  logic [9:0]            off_x,
  input  logic [9:0]            off_y,
  output logic                  empty,
  input  logic                  pop,
  output logic [11:0]           src_x,
  output logic [11:0]           src_y,
  output logic [23:0]           src_addr,
  output logic                  zero_fill,
  output logic                  in_tile,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [10:0] tile_size;
  logic [8:0]  overlap;
  logic        reflect_mode;
  cfg_t        cfg;
  logic        head_valid;
  front_item_t head;
  logic        credit;
  logic        issue;
  logic        src_valid;
  src_item_t   src_item;
  res_item_t   res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
      tile_size    <= 11'd256;
      overlap      <= 9'd16;
      reflect_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_TILE_SIZE:    tile_size    <= cfg_data[10:0];
        REG_OVERLAP:      overlap      <= cfg_data[8:0];
        REG_REFLECT_MODE: reflect_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.w       = (image_width > MAX_IMAGE) ? MAX_IMAGE : image_width;
    cfg.h       = (image_height > MAX_IMAGE) ? MAX_IMAGE : image_height;
    cfg.wm1     = cfg.w - 13'd1;
    cfg.hm1     = cfg.h - 13'd1;
    cfg.per_x   = {cfg.wm1[11:0], 1'b0};
    cfg.per_y   = {cfg.hm1[11:0], 1'b0};
    cfg.w_small = (cfg.w <= 13'd1);
    cfg.h_small = (cfg.h <= 13'd1);
    cfg.ts      = (tile_size > MAX_TILE) ? MAX_TILE : tile_size;
    cfg.ov      = overlap;
    cfg.refl    = reflect_mode;
  end

  assign issue = head_valid && credit;

  tsag_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .tile_x     (tile_x),
    .tile_y     (tile_y),
    .off_x      (off_x),
    .off_y      (off_y),
    .take       (issue),
    .head_valid (head_valid),
    .head       (head)
  );

  tsag_mirror u_mirror (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (issue),
    .in_item   (head),
    .out_valid (src_valid),
    .out_item  (src_item)
  );

  tsag_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .issue    (issue),
    .credit   (credit),
    .in_valid (src_valid),
    .in_item  (src_item),
    .pop      (pop),
    .empty    (empty),
    .head     (res)
  );

  assign src_x     = res.sx;
  assign src_y     = res.sy;
  assign src_addr  = res.addr;
  assign zero_fill = res.zf;
  assign in_tile   = res.hit;

  a_zero_fill_clears: assert property (@(posedge clk) disable iff (rst)
    (!empty && zero_fill) |-> (src_x == 12'd0 && src_y == 12'd0 && src_addr == 24'd0))
    else $error("zero-filled result carries a nonzero coordinate or address");

  a_reset_drains: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost without a pop");

endmodule

// ===== tb/tsag_address_checker.sv =====
// ----------------------------------------------------------------------------
// tsag_address_checker
// Watches the input, result and register channels of the tile source address
// generator. Each accepted item is turned into an expected source coordinate,
// plane address and flags, and each accepted result is compared with the
// oldest expectation in order.
// ----------------------------------------------------------------------------
module tsag_address_checker import tsag_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  logic [11:0]           tile_x,
  input  logic [11:0]           tile_y,
  input  logic [9:0]            off_x,
  input  logic [9:0]            off_y,
  input  logic                  empty,
  input  logic                  pop,
  input  logic [11:0]           src_x,
  input  logic [11:0]           src_y,
  input  logic [23:0]           src_addr,
  input  logic                  zero_fill,
  input  logic                  in_tile,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [12:0] reg_w;
  logic [12:0] reg_h;
  logic [10:0] reg_ts;
  logic [8:0]  reg_ov;
  logic        reg_refl;

  res_item_t pending_src_q[$];
  int        mismatches = 0;

  function automatic int mirror_coord(input int c, input int limit);
    int period;
    int m;
    if (limit <= 1) return 0;
    period = 2 * (limit - 1);
    m = c % period;
    if (m < 0) m += period;
    if (m >= limit) m = period - m;
    return m;
  endfunction

  function automatic void pad_axis(input int start, input int dim, input int ts,
                                   output int org, output int ext);
    int rem;
    org = start - int'(reg_ov);
    if (reg_refl) begin
      ext = ts;
    end else begin
      if (org < 0) org = 0;
      rem = dim - org;
      if (rem < 0) rem = 0;
      ext = (rem < ts) ? rem : ts;
    end
  endfunction

  function automatic res_item_t predict_source(input int tx, input int ty,
                                               input int ox, input int oy);
    int w;
    int h;
    int ts;
    int org_x;
    int org_y;
    int ext_x;
    int ext_y;
    int cx;
    int cy;
    res_item_t r;
    w  = (reg_w > MAX_IMAGE) ? int'(MAX_IMAGE) : int'(reg_w);
    h  = (reg_h > MAX_IMAGE) ? int'(MAX_IMAGE) : int'(reg_h);
    ts = (reg_ts > MAX_TILE) ? int'(MAX_TILE) : int'(reg_ts);
    pad_axis(tx, w, ts, org_x, ext_x);
    pad_axis(ty, h, ts, org_y, ext_y);
    r = '0;
    r.hit = (ox < ext_x) && (oy < ext_y);
    cx = org_x + ox;
    cy = org_y + oy;
    if (reg_refl) begin
      r.sx = 12'(mirror_coord(cx, w));
      r.sy = 12'(mirror_coord(cy, h));
    end else if (cx >= 0 && cx < w && cy >= 0 && cy < h) begin
      r.sx = 12'(cx);
      r.sy = 12'(cy);
    end else begin
      r.zf = 1'b1;
    end
    if (!r.zf) r.addr = 24'(int'(r.sy) * w + int'(r.sx));
    return r;
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    res_item_t got;
    if (rst) begin
      reg_w    <= 13'd1;
      reg_h    <= 13'd1;
      reg_ts   <= 11'd256;
      reg_ov   <= 9'd16;
      reg_refl <= 1'b0;
      pending_src_q.delete();
      outstanding <= 0;
    end else begin
      if (pop && !empty) begin
        got.sx   = src_x;
        got.sy   = src_y;
        got.addr = src_addr;
        got.zf   = zero_fill;
        got.hit  = in_tile;
        if (pending_src_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no item waiting: ", $time,
                     "sx=%0d sy=%0d addr=%0d zf=%0b in=%0b",
                     got.sx, got.sy, got.addr, got.zf, got.hit);
        end else begin
          want = pending_src_q.pop_front();
          if (got.sx !== want.sx || got.sy !== want.sy || got.addr !== want.addr ||
              got.zf !== want.zf || got.hit !== want.hit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch ", $time,
                       "exp sx=%0d sy=%0d addr=%0d zf=%0b in=%0b, ",
                       want.sx, want.sy, want.addr, want.zf, want.hit,
                       "got sx=%0d sy=%0d addr=%0d zf=%0b in=%0b",
                       got.sx, got.sy, got.addr, got.zf, got.hit);
          end
        end
      end
      if (push && !full)
        pending_src_q.insert(pending_src_q.size(),
                             predict_source(tile_x, tile_y, off_x, off_y));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  reg_w    <= cfg_data[12:0];
          REG_IMAGE_HEIGHT: reg_h    <= cfg_data[12:0];
          REG_TILE_SIZE:    reg_ts   <= cfg_data[10:0];
          REG_OVERLAP:      reg_ov   <= cfg_data[8:0];
          REG_REFLECT_MODE: reg_refl <= cfg_data[0];
          default: ;
        endcase
      end
      outstanding <= pending_src_q.size();
    end
    errors <= mismatches;
  end

endmodule

// ===== tb/tb_tile_source_address_generator_core.sv =====
// ----------------------------------------------------------------------------
// tb_tile_source_address_generator_core
// Drives tile origins and pixel offsets into the address generator under a
// series of image, tile and padding settings, with directed corner items
// followed by random items shaped around the image edges. The receiver
// stalls at random and once holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_tile_source_address_generator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tsag_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASES       = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  logic [11:0]           tile_x    = '0;
  logic [11:0]           tile_y    = '0;
  logic [9:0]            off_x     = '0;
  logic [9:0]            off_y     = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [11:0]           src_x;
  logic [11:0]           src_y;
  logic [23:0]           src_addr;
  logic                  zero_fill;
  logic                  in_tile;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int   errors;
  int   outstanding;
  int   cycle_count  = 0;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_ack     = 1'b0;
  int   hold_cnt     = 0;

  int cur_w  = 1;
  int cur_h  = 1;
  int cur_ts = 256;

  always #2 clk = ~clk;

  tile_source_address_generator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .off_x     (off_x),
    .off_y     (off_y),
    .empty     (empty),
    .pop       (pop),
    .src_x     (src_x),
    .src_y     (src_y),
    .src_addr  (src_addr),
    .zero_fill (zero_fill),
    .in_tile   (in_tile),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsag_address_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .off_x       (off_x),
    .off_y       (off_y),
    .empty       (empty),
    .pop         (pop),
    .src_x       (src_x),
    .src_y       (src_y),
    .src_addr    (src_addr),
    .zero_fill   (zero_fill),
    .in_tile     (in_tile),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      pop <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_item(input logic [11:0] tx, input logic [11:0] ty,
                           input logic [9:0] ox, input logic [9:0] oy);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    tile_x <= tx;
    tile_y <= ty;
    off_x  <= ox;
    off_y  <= oy;
    do @(posedge clk); while (full);
  endtask

  task automatic send_random_item();
    int span_x;
    int span_y;
    int span_off;
    if ($urandom_range(0, 9) < 7) begin
      span_x   = (cur_w + 16 > 4095) ? 4095 : cur_w + 16;
      span_y   = (cur_h + 16 > 4095) ? 4095 : cur_h + 16;
      span_off = (cur_ts + 4 > 1023) ? 1023 : cur_ts + 4;
      send_item(12'($urandom_range(0, span_x)), 12'($urandom_range(0, span_y)),
                10'($urandom_range(0, span_off)), 10'($urandom_range(0, span_off)));
    end else begin
      send_item(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input int w, input int h, input int ts,
                            input int ov, input int refl);
    cur_w  = (w > 4096) ? 4096 : w;
    cur_h  = (h > 4096) ? 4096 : h;
    cur_ts = (ts > 1024) ? 1024 : ts;
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_TILE_SIZE, ts);
    write_reg(REG_OVERLAP, ov);
    write_reg(REG_REFLECT_MODE, refl);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 1;
          2: return 4096;
          default: return 8191;
        endcase
      end
      1, 2, 3, 4: return $urandom_range(1, 64);
      5, 6, 7: return $urandom_range(1, 4096);
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  initial begin
    int ts;
    int ov;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(12'd0, 12'd0, 10'd0, 10'd0);
    send_item(12'd40, 12'd20, 10'd300, 10'd3);
    drain();

    write_regs(64, 48, 32, 8, 0);
    send_item(12'd0, 12'd0, 10'd0, 10'd0);
    send_item(12'd0, 12'd0, 10'd31, 10'd31);
    send_item(12'd0, 12'd0, 10'd32, 10'd0);
    send_item(12'd60, 12'd40, 10'd0, 10'd0);
    send_item(12'd60, 12'd40, 10'd20, 10'd20);
    send_item(12'd4095, 12'd4095, 10'd1023, 10'd1023);
    send_item(12'd100, 12'd100, 10'd5, 10'd5);
    drain();

    write_regs(64, 48, 32, 8, 1);
    send_item(12'd0, 12'd0, 10'd0, 10'd0);
    send_item(12'd0, 12'd0, 10'd1023, 10'd1023);
    send_item(12'd4095, 12'd0, 10'd0, 10'd0);
    send_item(12'd60, 12'd40, 10'd31, 10'd31);
    send_item(12'd10, 12'd10, 10'd32, 10'd5);
    drain();

    write_regs(1, 1, 2047, 511, 1);
    send_item(12'd4095, 12'd4095, 10'd1023, 10'd1023);
    send_item(12'd0, 12'd0, 10'd0, 10'd0);
    drain();

    write_regs(0, 0, 0, 0, 0);
    send_item(12'd0, 12'd0, 10'd0, 10'd0);
    send_item(12'd5, 12'd5, 10'd1, 10'd1);
    drain();

    write_regs(0, 8191, 1, 511, 1);
    send_item(12'd0, 12'd4095, 10'd0, 10'd0);
    send_item(12'd2048, 12'd100, 10'd1023, 10'd0);
    drain();

    write_regs(8191, 5000, 1024, 0, 0);
    send_item(12'd4095, 12'd4095, 10'd0, 10'd0);
    send_item(12'd3072, 12'd3072, 10'd1023, 10'd1023);
    send_item(12'd0, 12'd0, 10'd1023, 10'd1023);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      ts = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 64);
      ov = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 16) : $urandom_range(0, 511);
      write_regs(pick_dim(), pick_dim(), ts, ov, $urandom_range(0, 1));
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 49;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 49;
        end
        default: begin
          tx_idle_pct = 32;
          rx_stall_pct <= 32;
        end
      endcase
      if (p == 4) hold_req <= ~hold_req;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      push <= 1'b0;
      drain();
    end

    repeat (16) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
